// ----- hdl/ks_rk3_time_step_top_macros.svh -----
// Assertion shorthands for the time-step block.
// Both expect clk and arst_n in scope at the place of use.
`ifndef KS_RK3_TIME_STEP_TOP_MACROS_SVH
`define KS_RK3_TIME_STEP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/kst_pkg.sv -----
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, constants and helpers of the Runge-Kutta time-step block.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

	localparam int GRID_POINTS_DEF = 63;

	// Configuration register indexes.
	localparam logic REG_ADV_COEFF = 1'b0;
	localparam logic REG_TIME_STEP = 1'b1;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               last;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [5:0]         point_index;
		logic               final_res;
	} out_word_t;

	typedef enum logic [1:0] {
		PK_RHS,
		PK_UPD,
		PK_OUT
	} pass_kind_t;

	// One pass over the grid: what it does and how an update is scaled.
	typedef struct packed {
		pass_kind_t kind;
		logic       slope_sel;  // 0: first slope store, 1: second
		logic       neg;        // negative numerator
		logic       dbl;        // numerator magnitude two
		logic       half;       // denominator even
		logic       third;      // denominator divisible by three
	} pass_t;

	localparam logic [3:0] PASS_LAST = 4'd8;

	function automatic pass_t pass_desc(input logic [3:0] p);
		pass_t d;
		d = '{kind: PK_OUT, slope_sel: 1'b0, neg: 1'b0, dbl: 1'b0, half: 1'b0,
			third: 1'b0};
		case (p)
			4'd0: d.kind = PK_RHS;
			4'd1: begin
				d.kind = PK_UPD;
				d.half = 1'b1;
			end
			4'd2: begin
				d.kind = PK_RHS;
				d.slope_sel = 1'b1;
			end
			4'd3: begin
				d.kind = PK_UPD;
				d.neg = 1'b1;
				d.half = 1'b1;
				d.third = 1'b1;
			end
			4'd4: begin
				d.kind = PK_UPD;
				d.slope_sel = 1'b1;
				d.third = 1'b1;
			end
			4'd5: d.kind = PK_RHS;
			4'd6: begin
				d.kind = PK_UPD;
				d.slope_sel = 1'b1;
				d.neg = 1'b1;
				d.dbl = 1'b1;
				d.third = 1'b1;
			end
			4'd7: d.kind = PK_UPD;
			default: d.kind = PK_OUT;
		endcase
		return d;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ks_rk3_time_step_top.sv -----
// Loading accepts one sample per cycle while idle. The step starts on the last
// sample and runs three slope passes on the one shared 33x33 multiplier, five
// update passes, using the divide-by-three unit where needed, and an output pass.
// Results come one per grid point and cannot be stalled; busy is low from the
// final result on. Reset clears the configuration registers, the load count
// and control.
`default_nettype none
`include "ks_rk3_time_step_top_macros.svh"

// ----------------------------------------------------------------------------
// ks_rk3_time_step_top
// One three-stage Runge-Kutta step of a Kuramoto-Sivashinsky grid, computed
// point by point with a shared multiplier under a step sequencer.
// ----------------------------------------------------------------------------
module ks_rk3_time_step_top #(
	parameter int GRID_POINTS = kst_pkg::GRID_POINTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire kst_pkg::in_word_t item,
	output logic                   busy,
	output logic                   result_strobe,
	output kst_pkg::out_word_t     result,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [31:0]       cfg_data
);

	import kst_pkg::*;

	localparam int AW = $clog2(GRID_POINTS);
	localparam int P  = GRID_POINTS + 1;
	localparam logic signed [8:0]  P_S  = 9'(P);
	localparam logic signed [14:0] P2_S = 15'(P * P);
	localparam logic signed [26:0] P4_S = 27'(P * P * P * P);
	localparam logic [AW-1:0] LAST_SLOT = AW'(GRID_POINTS - 1);

	// Sequencer steps.
	localparam logic [3:0] S_RD0  = 4'd0;
	localparam logic [3:0] S_RD1  = 4'd1;
	localparam logic [3:0] S_RD2  = 4'd2;
	localparam logic [3:0] S_RD3  = 4'd3;
	localparam logic [3:0] S_RD4  = 4'd4;
	localparam logic [3:0] S_RD5  = 4'd5;
	localparam logic [3:0] S_SQP  = 4'd6;
	localparam logic [3:0] S_SQM  = 4'd7;
	localparam logic [3:0] S_ADV  = 4'd8;
	localparam logic [3:0] S_SUM  = 4'd9;
	localparam logic [3:0] S_WR   = 4'd10;
	localparam logic [3:0] U_RD   = 4'd0;
	localparam logic [3:0] U_CAP  = 4'd1;
	localparam logic [3:0] U_MUL  = 4'd2;
	localparam logic [3:0] U_SCL  = 4'd3;
	localparam logic [3:0] U_DIV  = 4'd4;
	localparam logic [3:0] U_WR   = 4'd5;
	localparam logic [3:0] O_RD   = 4'd0;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic [3:0]    pass_q;
	logic [3:0]    step_q;
	logic [AW-1:0] pt_q;
	logic [AW-1:0] lastpt_q;
	logic [AW-1:0] load_q;
	logic signed [31:0] coef_q;
	logic [19:0]        dt_q;
	logic               strobe_q;
	out_word_t          result_q;

	// Datapath registers.
	logic signed [31:0] c_q, up_q, upp_q, um_q, umm_q;
	logic signed [65:0] mul_q;
	logic signed [65:0] pp_q;
	logic signed [31:0] ux_q;
	logic signed [35:0] uxx_q;
	logic signed [35:0] u4_q;
	logic signed [45:0] sq_q;
	logic signed [45:0] adv_q;
	logic signed [46:0] half_q;
	logic signed [31:0] g_q;
	logic signed [31:0] k_q;
	logic signed [34:0] t_q;

	pass_t desc;
	logic  accept;

	// Memory ports.
	logic          grid_we;
	logic [AW-1:0] grid_waddr;
	logic signed [31:0] grid_wdata;
	logic [AW-1:0] grid_raddr;
	logic signed [31:0] grid_rdata;
	logic          sl0_we, sl1_we;
	logic signed [31:0] sl0_rdata, sl1_rdata;
	logic signed [31:0] k_new;

	// Neighbor bookkeeping.
	logic [AW:0] pt_x, last_x;
	logic up_ok, upp_ok, um_ok, umm_ok;

	// Shared multiplier operands.
	logic signed [32:0] mul_a, mul_b;

	// Slope terms.
	logic signed [32:0] d1;
	logic signed [41:0] pr1;
	logic signed [34:0] s2;
	logic signed [49:0] pr2;
	logic signed [36:0] s4;
	logic signed [63:0] pr4;
	logic signed [65:0] sqd;
	logic signed [55:0] prh;
	logic signed [67:0] ksum;

	// Update scaling.
	logic signed [67:0] xs;
	logic signed [67:0] ts;

	logic               div_go;
	logic               div_done;
	logic signed [34:0] div_q;

	always_comb begin
		desc   = pass_desc(pass_q);
		accept = start && (state_q == ST_IDLE);
		pt_x   = {1'b0, pt_q};
		last_x = {1'b0, lastpt_q};
		up_ok  = pt_x < last_x;
		upp_ok = (pt_x + (AW+1)'(2)) <= last_x;
		um_ok  = pt_q != '0;
		umm_ok = pt_x >= (AW+1)'(2);
	end

	// Read address of the grid store.
	always_comb begin
		grid_raddr = pt_q;
		if (desc.kind == PK_RHS) begin
			case (step_q)
				S_RD1: grid_raddr = up_ok ? AW'(pt_x + (AW+1)'(1)) : pt_q;
				S_RD2: grid_raddr = upp_ok ? AW'(pt_x + (AW+1)'(2)) : pt_q;
				S_RD3: grid_raddr = um_ok ? AW'(pt_x - (AW+1)'(1)) : pt_q;
				S_RD4: grid_raddr = umm_ok ? AW'(pt_x - (AW+1)'(2)) : pt_q;
				default: grid_raddr = pt_q;
			endcase
		end
	end

	always_comb begin
		mul_a = 33'(up_q);
		mul_b = 33'(up_q);
		if (desc.kind == PK_UPD) begin
			mul_a = 33'({1'b0, dt_q});
			mul_b = 33'(k_q);
		end else begin
			case (step_q)
				S_SQM: begin
					mul_a = 33'(um_q);
					mul_b = 33'(um_q);
				end
				S_ADV: begin
					mul_a = 33'(coef_q);
					mul_b = 33'(ux_q);
				end
				default: begin
					mul_a = 33'(up_q);
					mul_b = 33'(up_q);
				end
			endcase
		end
	end

	always_comb begin
		d1   = 33'(up_q) - 33'(um_q);
		pr1  = 42'(d1) * 42'(P_S);
		s2   = 35'(up_q) + 35'(um_q) - (35'(c_q) <<< 1);
		pr2  = 50'(s2) * 50'(P2_S);
		s4   = 37'(upp_q) + 37'(umm_q) - (37'(up_q) <<< 2) - (37'(um_q) <<< 2)
			+ (37'(c_q) <<< 2) + (37'(c_q) <<< 1);
		pr4  = 64'(s4) * 64'(P4_S);
		sqd  = pp_q - mul_q;
		prh  = 56'(sq_q) * 56'(P_S);
		ksum = -68'(adv_q) - 68'(half_q) - 68'(uxx_q) - 68'(u4_q);
		k_new = sat32(ksum);

		xs = 68'(mul_q);
		if (desc.neg) begin
			xs = -xs;
		end
		if (desc.dbl) begin
			xs = xs <<< 1;
		end
		ts = xs >>> 20;
		if (desc.half) begin
			ts = ts >>> 1;
		end
	end

	always_comb begin
		grid_we    = 1'b0;
		grid_waddr = pt_q;
		grid_wdata = sat32(68'(g_q) + 68'(t_q));
		if (accept) begin
			grid_we    = 1'b1;
			grid_waddr = load_q;
			grid_wdata = item.sample;
		end else if (state_q == ST_RUN && desc.kind == PK_UPD && step_q == U_WR) begin
			grid_we = 1'b1;
		end
		sl0_we = state_q == ST_RUN && desc.kind == PK_RHS && step_q == S_WR
			&& !desc.slope_sel;
		sl1_we = state_q == ST_RUN && desc.kind == PK_RHS && step_q == S_WR
			&& desc.slope_sel;
		div_go = state_q == ST_RUN && desc.kind == PK_UPD && step_q == U_SCL
			&& desc.third;
	end

	kst_ram #(.DEPTH(GRID_POINTS), .AW(AW)) u_grid (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (grid_wdata),
		.raddr (grid_raddr),
		.rdata (grid_rdata)
	);

	kst_ram #(.DEPTH(GRID_POINTS), .AW(AW)) u_slope0 (
		.clk   (clk),
		.we    (sl0_we),
		.waddr (pt_q),
		.wdata (k_new),
		.raddr (pt_q),
		.rdata (sl0_rdata)
	);

	kst_ram #(.DEPTH(GRID_POINTS), .AW(AW)) u_slope1 (
		.clk   (clk),
		.we    (sl1_we),
		.waddr (pt_q),
		.wdata (k_new),
		.raddr (pt_q),
		.rdata (sl1_rdata)
	);

	kst_div3 u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (ts[34:0]),
		.done     (div_done),
		.quotient (div_q)
	);

	// Moves to the next point, or after the last point to the next pass
	// (to idle in the output pass). Control state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pass_q   <= '0;
			step_q   <= '0;
			pt_q     <= '0;
			lastpt_q <= '0;
			load_q   <= '0;
			coef_q   <= '0;
			dt_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ADV_COEFF: coef_q <= cfg_data;
					REG_TIME_STEP: dt_q   <= cfg_data[19:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.last) begin
							lastpt_q <= load_q;
							load_q   <= '0;
							pass_q   <= '0;
							step_q   <= '0;
							pt_q     <= '0;
							state_q  <= ST_RUN;
						end else if (load_q != LAST_SLOT) begin
							load_q <= load_q + AW'(1);
						end
					end
				end
				ST_RUN: begin
					case (desc.kind)
						PK_RHS: begin
							if (step_q == S_WR) begin
								step_q <= '0;
								if (pt_q == lastpt_q) begin
									pt_q   <= '0;
									pass_q <= pass_q + 4'd1;
								end else begin
									pt_q <= pt_q + AW'(1);
								end
							end else begin
								step_q <= step_q + 4'd1;
							end
						end
						PK_UPD: begin
							case (step_q)
								U_SCL: step_q <= desc.third ? U_DIV : U_WR;
								U_DIV: begin
									if (div_done) begin
										step_q <= U_WR;
									end
								end
								U_WR: begin
									step_q <= '0;
									if (pt_q == lastpt_q) begin
										pt_q   <= '0;
										pass_q <= pass_q + 4'd1;
									end else begin
										pt_q <= pt_q + AW'(1);
									end
								end
								default: step_q <= step_q + 4'd1;
							endcase
						end
						default: begin
							if (step_q == O_RD) begin
								step_q <= step_q + 4'd1;
							end else begin
								strobe_q <= 1'b1;
								step_q   <= '0;
								if (pt_q == lastpt_q) begin
									state_q <= ST_IDLE;
								end else begin
									pt_q <= pt_q + AW'(1);
								end
							end
						end
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath words.
	always_ff @(posedge clk) begin
		mul_q <= 66'(mul_a) * 66'(mul_b);
		if (desc.kind == PK_RHS) begin
			case (step_q)
				S_RD1: c_q <= grid_rdata;
				S_RD2: up_q <= up_ok ? grid_rdata : 32'sd0;
				S_RD3: upp_q <= upp_ok ? grid_rdata : c_q;
				S_RD4: um_q <= um_ok ? grid_rdata : 32'sd0;
				S_RD5: umm_q <= umm_ok ? grid_rdata : c_q;
				S_SQP: ux_q <= sat32(68'(pr1 >>> 8));
				S_SQM: begin
					pp_q  <= mul_q;
					uxx_q <= pr2[49:14];
				end
				S_ADV: begin
					sq_q <= sqd[65:20];
					u4_q <= pr4[63:28];
				end
				S_SUM: begin
					adv_q  <= mul_q[65:20];
					half_q <= prh[55:9];
				end
				default: ;
			endcase
		end else if (desc.kind == PK_UPD) begin
			case (step_q)
				U_CAP: begin
					g_q <= grid_rdata;
					k_q <= desc.slope_sel ? sl1_rdata : sl0_rdata;
				end
				U_SCL: t_q <= ts[34:0];
				U_DIV: begin
					if (div_done) begin
						t_q <= div_q;
					end
				end
				default: ;
			endcase
		end else if (step_q != O_RD) begin
			result_q.value       <= grid_rdata;
			result_q.point_index <= 6'(pt_q);
			result_q.final_res   <= pt_q == lastpt_q;
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign result_strobe = strobe_q;
	assign result        = result_q;

	`KST_ASSERT_NOW(a_mid_result_busy, result_strobe && !result.final_res, busy, "result word before the final one without busy")
	`KST_ASSERT_NEXT(a_load_stays_idle, start && !busy && !item.last, !busy, "non-final sample started a step")
	`KST_ASSERT_NOW(a_step_from_last, $rose(busy), $past(start && item.last), "step started without a final sample")
	`KST_ASSERT_NOW(a_final_ends_step, result_strobe && result.final_res, !busy, "block still busy at the final result word")

endmodule

`default_nettype wire

// ----- hdl/kst_ram.sv -----
// ----------------------------------------------------------------------------
// kst_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_ram #(
	parameter int DEPTH = 63,
	parameter int AW    = 6
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic signed [31:0]   wdata,
	input  wire logic [AW-1:0]        raddr,
	output logic signed [31:0]        rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/kst_div3.sv -----
// ----------------------------------------------------------------------------
// kst_div3
// Floor division of a signed value by three, by reciprocal multiplication in
// two steps, upper bits then lower bits; done rises as the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_div3 (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic signed [34:0] dividend,
	output logic                    done,
	output logic signed [34:0]      quotient
);

	// The dividend is lifted by three times 2^34 so the division is unsigned;
	// the quotient then comes back down by 2^34.
	localparam logic [35:0] OFFSET   = 36'hC_0000_0000;
	localparam logic [34:0] UNSHIFT  = 35'h4_0000_0000;
	// Rounded-up reciprocals of three, scaled by 2^20 and 2^22. Each gives an
	// exact floor quotient for the operand range it is used on.
	localparam logic [18:0] RECIP_HI = 19'h5_5556;
	localparam logic [20:0] RECIP_LO = 21'h15_5556;

	logic [35:0] num_q;
	logic [16:0] qh_q;
	logic [19:0] lo_q;
	logic [34:0] quo_q;
	logic        ph1_q;
	logic        ph2_q;
	logic        done_q;

	logic [36:0] prod_hi;
	logic [16:0] qh;
	logic [17:0] h3;
	logic [1:0]  rh;
	logic [39:0] prod_lo;
	logic [17:0] ql;

	always_comb begin
		// Upper 18 bits first; their remainder is carried into the lower part.
		prod_hi = 37'(num_q[35:18]) * 37'(RECIP_HI);
		qh      = prod_hi[36:20];
		h3      = 18'(qh) + (18'(qh) << 1);
		rh      = 2'(num_q[35:18] - h3);
		prod_lo = 40'(lo_q) * 40'(RECIP_LO);
		ql      = prod_lo[39:22];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph1_q  <= 1'b0;
			ph2_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ph1_q  <= go;
			ph2_q  <= ph1_q;
			done_q <= ph2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= 36'(dividend) + OFFSET;
		end
		if (ph1_q) begin
			qh_q <= qh;
			lo_q <= {rh, num_q[17:0]};
		end
		if (ph2_q) begin
			quo_q <= {qh_q, ql};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q - UNSHIFT;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Runge-Kutta Kuramoto-Sivashinsky time-step block.
// Grids of random size and content are loaded word by word across several
// coefficient and step-size settings. A built-in predictor steps each grid and
// checks every returned point in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kst_pkg::*;

	localparam int  NPTS = GRID_POINTS_DEF;
	localparam longint PP = NPTS + 1;
	localparam longint CYCLE_LIMIT = 3_000_000;

	logic       clk;
	logic       arst_n;
	logic       start;
	in_word_t   item;
	logic       busy;
	logic       result_strobe;
	out_word_t  result;
	logic       cfg_we;
	logic       cfg_index;
	logic [31:0] cfg_data;

	ks_rk3_time_step_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.result_strobe(result_strobe), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	in_word_t  pend_q[$];
	out_word_t grid_out_q[$];
	int        idle_pct = 0;
	int        err_count = 0;
	int        steps_run = 0;
	int        points_seen = 0;
	longint    cyc = 0;

	// Predictor state.
	longint coef_m = 0;
	longint dt_m = 0;
	int     load_m = 0;
	int     grid_m[NPTS];
	int     slope_a[NPTS];
	int     slope_b[NPTS];

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint div_down(input longint a, input longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0) q = q - 1;
		return q;
	endfunction

	function automatic void calc_slope(input int n, input bit to_b);
		longint c, up, upp, um, umm, ux, adv, sq, hf, uxx, u4, k;
		for (int i = 0; i < n; i++) begin
			c = grid_m[i];
			up = (i < n - 1) ? longint'(grid_m[i + 1]) : 0;
			upp = (i < n - 2) ? longint'(grid_m[i + 2]) : c;
			um = (i > 0) ? longint'(grid_m[i - 1]) : 0;
			umm = (i > 1) ? longint'(grid_m[i - 2]) : c;
			ux = clamp32(((up - um) * PP) >>> 8);
			adv = (coef_m * ux) >>> 20;
			sq = (up * up - um * um) >>> 20;
			hf = (sq * PP) >>> 9;
			uxx = ((up + um - 2 * c) * PP * PP) >>> 14;
			u4 = ((upp + umm - 4 * up - 4 * um + 6 * c) * PP * PP * PP * PP) >>> 28;
			k = clamp32(-adv - hf - uxx - u4);
			if (to_b) slope_b[i] = int'(k);
			else slope_a[i] = int'(k);
		end
	endfunction

	function automatic void apply_update(input int n, input bit from_b, input longint num,
			input longint den);
		longint k, inc;
		for (int i = 0; i < n; i++) begin
			k = from_b ? longint'(slope_b[i]) : longint'(slope_a[i]);
			inc = div_down(dt_m * k * num, den << 20);
			grid_m[i] = int'(clamp32(longint'(grid_m[i]) + inc));
		end
	endfunction

	function automatic void step_grid(input in_word_t w);
		int idx, n;
		out_word_t o;
		idx = (load_m > NPTS - 1) ? NPTS - 1 : load_m;
		grid_m[idx] = w.sample;
		if (!w.last) begin
			if (idx < NPTS - 1) idx++;
			load_m = idx;
			return;
		end
		n = idx + 1;
		calc_slope(n, 1'b0);
		apply_update(n, 1'b0, 1, 2);
		calc_slope(n, 1'b1);
		apply_update(n, 1'b0, -1, 6);
		apply_update(n, 1'b1, 1, 3);
		calc_slope(n, 1'b0);
		apply_update(n, 1'b1, -2, 3);
		apply_update(n, 1'b0, 1, 1);
		for (int i = 0; i < n; i++) begin
			o.value = grid_m[i];
			o.point_index = 6'(i);
			o.final_res = (i == n - 1);
			grid_out_q.push_back(o);
		end
		load_m = 0;
		steps_run++;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: presents queued words and runs the predictor on each accepted one.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy) step_grid(item);
			if (!(start && busy)) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					item <= pend_q.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result must match the oldest expected point.
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && result_strobe) begin
			points_seen++;
			if (grid_out_q.size() == 0) begin
				$error("unexpected result word, value %0d", result.value);
				err_count++;
			end else begin
				e = grid_out_q.pop_front();
				if (result.value !== e.value) begin
					$error("value: expected %0d, got %0d", e.value, result.value);
					err_count++;
				end
				if (result.point_index !== e.point_index) begin
					$error("point_index: expected %0d, got %0d", e.point_index,
						result.point_index);
					err_count++;
				end
				if (result.final_res !== e.final_res) begin
					$error("final_res: expected %0d, got %0d", e.final_res,
						result.final_res);
					err_count++;
				end
			end
		end
	end

	function automatic logic signed [31:0] pick_sample(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21);
			default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		endcase
	endfunction

	task automatic add_grid(input int n, input int mode);
		in_word_t w;
		for (int i = 0; i < n; i++) begin
			w.sample = pick_sample(mode);
			w.last = (i == n - 1);
			pend_q.push_back(w);
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pend_q.size() != 0 || grid_out_q.size() != 0 || start || busy);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_ADV_COEFF) coef_m = longint'($signed(data));
		else dt_m = longint'(data[19:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_grids(input int words);
		int pushed, n, r;
		pushed = 0;
		while (pushed < words) begin
			r = $urandom_range(29);
			if (r == 0) n = NPTS;
			else if (r == 1) n = $urandom_range(NPTS + 1, NPTS + 5);
			else n = $urandom_range(1, 10);
			add_grid(n, $urandom_range(2));
			pushed += n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ADV_COEFF;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single point, two points, then short grids with extreme, small and full-range samples.
		write_reg(REG_ADV_COEFF, 32'h0010_0000);
		write_reg(REG_TIME_STEP, 32'h0001_0000);
		add_grid(1, 2);
		add_grid(2, 2);
		add_grid(3, 1);
		add_grid(5, 2);
		add_grid(5, 0);
		add_grid(6, 1);
		idle_pct = 0;
		wait_drained();
		random_grids(50);
		wait_drained();

		write_reg(REG_ADV_COEFF, 32'h7FFF_FFFF);
		write_reg(REG_TIME_STEP, 32'h000F_FFFF);
		idle_pct = 82;
		random_grids(55);
		wait_drained();

		write_reg(REG_ADV_COEFF, 32'h8000_0000);
		write_reg(REG_TIME_STEP, 32'h0000_0000);
		idle_pct = 27;
		random_grids(45);
		wait_drained();

		write_reg(REG_ADV_COEFF, $urandom);
		write_reg(REG_TIME_STEP, 32'($urandom_range(0, 20'hF_FFFF)));
		idle_pct = 0;
		random_grids(50);
		wait_drained();
		repeat (300) @(posedge clk);

		$display("Ran %0d grid steps and checked %0d returned points", steps_run,
			points_seen);
		$display("over four coefficient and step-size settings with varied input gaps.");
		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/kst_pkg.sv
hdl/kst_ram.sv
hdl/kst_div3.sv
hdl/ks_rk3_time_step_top.sv
tb/sv/tb.sv
